>>> src/phpwm_pkg.sv
// ----------------------------------------------------------------------------
// phpwm_pkg
// Shared types, constants and helpers for the PID phase loop with
// third-harmonic PWM.
// ----------------------------------------------------------------------------
package phpwm_pkg;

	// Quarter-wave sine resolution (entries = 2**SINE_LOG2, at most 2**14)
	localparam int SINE_LOG2    = 10;
	localparam int SINE_ENTRIES = 1 << SINE_LOG2;
	localparam int POLE_PAIRS_DEF = 7;

	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [28:0] HARM_GAIN_Q32  = 29'd413283421;
	localparam logic [15:0] THIRD_TURN     = 16'd21845;

	// Sine polynomial coefficients, Q30
	localparam logic [30:0] C1_Q30 = 31'd1686629713;
	localparam logic [30:0] C3_Q30 = 31'd693598668;
	localparam logic [30:0] C5_Q30 = 31'd85569306;
	localparam logic [30:0] C7_Q30 = 31'd5026991;
	localparam logic [30:0] C9_Q30 = 31'd172272;

	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_REACH_THR = 3'd3,
		REG_PWM_PER   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] goal_pos;
		logic               motor_select;
	} in_item_t;

	typedef struct packed {
		logic [15:0] duty_u_high;
		logic [15:0] duty_v_high;
		logic [15:0] duty_w_high;
		logic [15:0] duty_u_low;
		logic [15:0] duty_v_low;
		logic [15:0] duty_w_low;
		logic        at_goal;
		logic        duties_applied;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic        [30:0] reach_threshold;
		logic        [15:0] pwm_top;
	} cfg_t;

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [42:0] x);
		if (x > 43'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (x < -43'sd2147483648)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

	// Horner step coefficient: C7, C5, C3, C1
	function automatic logic [30:0] poly_coef(input logic [1:0] k);
		case (k)
			2'd0:    return C7_Q30;
			2'd1:    return C5_Q30;
			2'd2:    return C3_Q30;
			default: return C1_Q30;
		endcase
	endfunction

endpackage

>>> src/pid_phase_loop_with_harmonic_pwm_core.sv
// ----------------------------------------------------------------------------
// pid_phase_loop_with_harmonic_pwm_core
// Position PID loop driving a three-phase PWM with third-harmonic injection.
// ----------------------------------------------------------------------------
// Sequencing: each sine runs the squaring and Horner steps on the shared
//   multiplier, skipped at an exact quarter turn (at most two of the four
//   sines per tick); the output state waits while the output register is full.
// Flow: the single multiplier sequencer works on one tick at a time;
//   a two-entry input queue and an output register decouple sides.
// Reset: arst_n clears loop state, queue and output valid, and loads the
//   register defaults; no clearing pass is needed.
module pid_phase_loop_with_harmonic_pwm_core #(
	parameter int POLE_PAIRS = phpwm_pkg::POLE_PAIRS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  phpwm_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output phpwm_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import phpwm_pkg::*;

	cfg_t     cfg_q;
	logic     head_valid;
	in_item_t head_data;
	logic     head_pop;

	assign cfg_ready = 1'b1;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= 16'sd256;
			cfg_q.gain_i          <= 16'sd0;
			cfg_q.gain_d          <= 16'sd0;
			cfg_q.reach_threshold <= 31'd655;
			cfg_q.pwm_top         <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_GAIN_P:    cfg_q.gain_p          <= cfg_data[15:0];
				REG_GAIN_I:    cfg_q.gain_i          <= cfg_data[15:0];
				REG_GAIN_D:    cfg_q.gain_d          <= cfg_data[15:0];
				REG_REACH_THR: cfg_q.reach_threshold <= cfg_data[30:0];
				REG_PWM_PER:   cfg_q.pwm_top         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	phpwm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.head_valid (head_valid),
		.head_data  (head_data),
		.head_pop   (head_pop)
	);

	phpwm_back #(
		.POLE_PAIRS (POLE_PAIRS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_data  (head_data),
		.head_pop   (head_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

>>> src/phpwm_front.sv
// ----------------------------------------------------------------------------
// phpwm_front
// Input side: takes control ticks and holds them in a two-entry queue
// until the back end picks them up.
// ----------------------------------------------------------------------------
module phpwm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  phpwm_pkg::in_item_t in_data,
	output logic                head_valid,
	output phpwm_pkg::in_item_t head_data,
	input  logic                head_pop
);
	import phpwm_pkg::*;

	in_item_t    slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid & in_ready;
	assign pop        = head_pop & head_valid;
	assign head_valid = (count_q != 2'd0);
	assign head_data  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= in_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

>>> src/phpwm_back.sv
// ----------------------------------------------------------------------------
// phpwm_back
// Sequencer around one shared 34x34 multiplier: PID terms, phase advance,
// four sines from the Taylor polynomial, duties and position update.
// ----------------------------------------------------------------------------
module phpwm_back #(
	parameter int POLE_PAIRS = phpwm_pkg::POLE_PAIRS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  phpwm_pkg::cfg_t      cfg,
	input  logic                 head_valid,
	input  phpwm_pkg::in_item_t  head_data,
	output logic                 head_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output phpwm_pkg::out_item_t out_data
);
	import phpwm_pkg::*;

	localparam logic [31:0] RECIP = 32'(64'd4294967295 / POLE_PAIRS);
	localparam logic [6:0]  PP    = 7'(POLE_PAIRS);

	typedef enum logic [24:0] {
		ST_IDLE  = 25'd1 << 0,
		ST_ERR   = 25'd1 << 1,
		ST_MP    = 25'd1 << 2,
		ST_MI    = 25'd1 << 3,
		ST_MD    = 25'd1 << 4,
		ST_SUM   = 25'd1 << 5,
		ST_U     = 25'd1 << 6,
		ST_STEP  = 25'd1 << 7,
		ST_PH    = 25'd1 << 8,
		ST_SSET  = 25'd1 << 9,
		ST_SSQ   = 25'd1 << 10,
		ST_SS    = 25'd1 << 11,
		ST_SPOLY = 25'd1 << 12,
		ST_SPUPD = 25'd1 << 13,
		ST_SR    = 25'd1 << 14,
		ST_SFIN  = 25'd1 << 15,
		ST_DM    = 25'd1 << 16,
		ST_DF    = 25'd1 << 17,
		ST_DP    = 25'd1 << 18,
		ST_DW    = 25'd1 << 19,
		ST_DV1   = 25'd1 << 20,
		ST_DV2   = 25'd1 << 21,
		ST_DV3   = 25'd1 << 22,
		ST_DV4   = 25'd1 << 23,
		ST_OUT   = 25'd1 << 24
	} state_t;

	state_t state_q;

	// loop state
	logic signed [31:0] error_sum_q;
	logic signed [31:0] last_error_q;
	logic        [15:0] phase_q;
	logic signed [31:0] pos_q;

	// per-tick working registers
	logic signed [31:0] tgt_q;
	logic               sel_q;
	logic signed [31:0] e_q;
	logic signed [32:0] diff_q;
	logic               reached_q;
	logic signed [41:0] acc_q;
	logic signed [31:0] u_q;
	logic        [29:0] z_q;
	logic        [29:0] s_q;
	logic        [30:0] p_q;
	logic               neg_q;
	logic signed [17:0] sv_q [4];
	logic        [16:0] f_q;
	logic        [15:0] duty_q [3];
	logic        [31:0] q0_q;
	logic        [1:0]  sin_cnt_q;
	logic        [1:0]  poly_cnt_q;
	logic        [1:0]  duty_cnt_q;
	logic signed [67:0] prod_q;
	out_item_t          res_q;
	logic               res_v_q;

	// shared multiplier operands
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;

	logic signed [32:0] e_wide;
	logic signed [31:0] e_new;
	logic        [31:0] e_mag;
	logic        [31:0] u_abs;
	logic        [15:0] angle;
	logic        [1:0]  quad;
	logic [SINE_LOG2-1:0] idx;
	logic [SINE_LOG2:0]   jdx;
	logic        [31:0] r_raw;
	logic        [18:0] r_rnd;
	logic        [16:0] r_mag;
	logic signed [17:0] s_sel;
	logic signed [20:0] m_val;
	logic signed [20:0] f_raw;
	logic        [32:0] rem;
	logic        [31:0] q_fix;
	logic signed [42:0] q_s;
	logic               out_take;
	logic               res_load;

	// error and magnitude
	assign e_wide = 33'(tgt_q) - 33'(pos_q);
	assign e_new  = sat32(43'(e_wide));
	assign e_mag  = e_q[31] ? 32'(-33'(e_q)) : 32'(e_q);
	assign u_abs  = u_q[31] ? 32'(-33'(u_q)) : 32'(u_q);

	// sine angle decode: quadrant, mirrored quarter index
	always_comb begin
		case (sin_cnt_q)
			2'd0:    angle = phase_q;
			2'd1:    angle = phase_q - THIRD_TURN;
			2'd2:    angle = phase_q + THIRD_TURN;
			default: angle = (phase_q << 1) + phase_q;
		endcase
	end
	assign quad = angle[15:14];
	assign idx  = SINE_LOG2'(angle[13:0] >> (14 - SINE_LOG2));
	assign jdx  = quad[0] ? ((SINE_LOG2+1)'(SINE_ENTRIES) - {1'b0, idx}) : {1'b0, idx};

	// sine rounding to Q0.16
	assign r_raw = prod_q[61:30];
	assign r_rnd = 19'((33'(r_raw) + 33'd8192) >> 14);
	assign r_mag = (r_rnd > 19'd65535) ? 17'd65535 : r_rnd[16:0];

	// harmonic mix m = 6*s + s3
	assign s_sel = (duty_cnt_q == 2'd0) ? sv_q[0] : ((duty_cnt_q == 2'd1) ? sv_q[1] : sv_q[2]);
	assign m_val = (21'(s_sel) <<< 2) + (21'(s_sel) <<< 1) + 21'(sv_q[3]);
	assign f_raw = signed'(prod_q[52:32]) + 21'sd32768;

	// position correction after reciprocal multiply
	assign rem   = {1'b0, u_abs} - prod_q[32:0];
	assign q_fix = (rem >= 33'(PP)) ? (q0_q + 32'd1) : q0_q;
	assign q_s   = signed'({11'd0, q_fix});

	assign head_pop  = (state_q == ST_IDLE) && head_valid;
	assign out_take  = res_v_q && out_ready;
	assign res_load  = (state_q == ST_OUT) && (!res_v_q || out_ready);
	assign out_valid = res_v_q;
	assign out_data  = res_q;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MP: begin
				mul_a = 34'(cfg.gain_p);
				mul_b = 34'(e_q);
			end
			ST_MI: begin
				mul_a = 34'(cfg.gain_i);
				mul_b = 34'(error_sum_q);
			end
			ST_MD: begin
				mul_a = 34'(cfg.gain_d);
				mul_b = 34'(diff_q);
			end
			ST_STEP: begin
				mul_a = 34'(u_q);
				mul_b = {4'd0, INV_TWO_PI_Q32};
			end
			ST_SSQ: begin
				mul_a = {4'd0, z_q};
				mul_b = {4'd0, z_q};
			end
			ST_SPOLY: begin
				mul_a = {3'd0, p_q};
				mul_b = {4'd0, s_q};
			end
			ST_SR: begin
				mul_a = {3'd0, p_q};
				mul_b = {4'd0, z_q};
			end
			ST_DM: begin
				mul_a = 34'(m_val);
				mul_b = {5'd0, HARM_GAIN_Q32};
			end
			ST_DP: begin
				mul_a = {17'd0, f_q};
				mul_b = {18'd0, cfg.pwm_top};
			end
			ST_DV1: begin
				mul_a = {2'd0, u_abs};
				mul_b = {2'd0, RECIP};
			end
			ST_DV3: begin
				mul_a = {2'd0, q0_q};
				mul_b = {27'd0, PP};
			end
			default: ;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				tgt_q <= head_data.goal_pos;
				sel_q <= head_data.motor_select;
			end
			ST_ERR: begin
				e_q    <= e_new;
				diff_q <= 33'(e_new) - 33'(last_error_q);
			end
			ST_MP:  reached_q <= (e_mag < {1'b0, cfg.reach_threshold});
			ST_MI:  acc_q <= 42'(prod_q >>> 8);
			ST_MD:  acc_q <= acc_q + 42'(prod_q >>> 8);
			ST_SUM: acc_q <= acc_q + 42'(prod_q >>> 8);
			ST_U:   u_q   <= sat32(43'(acc_q));
			ST_SSET: begin
				neg_q <= quad[1];
				z_q   <= 30'(jdx[SINE_LOG2-1:0]) << (30 - SINE_LOG2);
				if (jdx[SINE_LOG2])
					sv_q[sin_cnt_q] <= quad[1] ? -18'sd65536 : 18'sd65536;
			end
			ST_SS: begin
				s_q <= prod_q[59:30];
				p_q <= C9_Q30;
			end
			ST_SPUPD: p_q <= poly_coef(poly_cnt_q) - prod_q[60:30];
			ST_SFIN:  sv_q[sin_cnt_q] <= neg_q ? -18'(r_mag) : 18'(r_mag);
			ST_DF: begin
				if (f_raw < 21'sd0)
					f_q <= 17'd0;
				else if (f_raw > 21'sd65536)
					f_q <= 17'd65536;
				else
					f_q <= f_raw[16:0];
			end
			ST_DW:  duty_q[duty_cnt_q] <= prod_q[31:16];
			ST_DV2: q0_q <= prod_q[63:32];
			ST_OUT: begin
				if (res_load) begin
					res_q.duty_u_high    <= sel_q ? duty_q[0] : 16'd0;
					res_q.duty_v_high    <= sel_q ? duty_q[1] : 16'd0;
					res_q.duty_w_high    <= sel_q ? duty_q[2] : 16'd0;
					res_q.duty_u_low     <= sel_q ? (cfg.pwm_top - duty_q[0]) : 16'd0;
					res_q.duty_v_low     <= sel_q ? (cfg.pwm_top - duty_q[1]) : 16'd0;
					res_q.duty_w_low     <= sel_q ? (cfg.pwm_top - duty_q[2]) : 16'd0;
					res_q.at_goal        <= reached_q;
					res_q.duties_applied <= sel_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			error_sum_q  <= '0;
			last_error_q <= '0;
			phase_q      <= '0;
			pos_q        <= '0;
			sin_cnt_q    <= '0;
			poly_cnt_q   <= '0;
			duty_cnt_q   <= '0;
			res_v_q      <= 1'b0;
		end else begin
			if (res_load)
				res_v_q <= 1'b1;
			else if (out_take)
				res_v_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: if (head_valid) state_q <= ST_ERR;
				ST_ERR: begin
					error_sum_q <= sat32(43'(error_sum_q) + 43'(e_new));
					state_q     <= ST_MP;
				end
				ST_MP:   state_q <= ST_MI;
				ST_MI:   state_q <= ST_MD;
				ST_MD:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_U;
				ST_U:    state_q <= ST_STEP;
				ST_STEP: state_q <= ST_PH;
				ST_PH: begin
					phase_q   <= phase_q + prod_q[47:32];
					sin_cnt_q <= 2'd0;
					state_q   <= ST_SSET;
				end
				ST_SSET: begin
					if (!jdx[SINE_LOG2])
						state_q <= ST_SSQ;
					else if (sin_cnt_q == 2'd3) begin
						duty_cnt_q <= 2'd0;
						state_q    <= ST_DM;
					end else
						sin_cnt_q <= sin_cnt_q + 2'd1;
				end
				ST_SSQ: state_q <= ST_SS;
				ST_SS: begin
					poly_cnt_q <= 2'd0;
					state_q    <= ST_SPOLY;
				end
				ST_SPOLY: state_q <= ST_SPUPD;
				ST_SPUPD: begin
					poly_cnt_q <= poly_cnt_q + 2'd1;
					state_q    <= (poly_cnt_q == 2'd3) ? ST_SR : ST_SPOLY;
				end
				ST_SR: state_q <= ST_SFIN;
				ST_SFIN: begin
					if (sin_cnt_q == 2'd3) begin
						duty_cnt_q <= 2'd0;
						state_q    <= ST_DM;
					end else begin
						sin_cnt_q <= sin_cnt_q + 2'd1;
						state_q   <= ST_SSET;
					end
				end
				ST_DM: state_q <= ST_DF;
				ST_DF: state_q <= ST_DP;
				ST_DP: state_q <= ST_DW;
				ST_DW: begin
					if (duty_cnt_q == 2'd2)
						state_q <= ST_DV1;
					else begin
						duty_cnt_q <= duty_cnt_q + 2'd1;
						state_q    <= ST_DM;
					end
				end
				ST_DV1: state_q <= ST_DV2;
				ST_DV2: state_q <= ST_DV3;
				ST_DV3: state_q <= ST_DV4;
				ST_DV4: begin
					pos_q        <= u_q[31] ? sat32(43'(pos_q) - q_s) : sat32(43'(pos_q) + q_s);
					last_error_q <= e_q;
					state_q      <= ST_OUT;
				end
				ST_OUT: if (res_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
